// ----- hw/rtl/weighted_round_robin_backend_pick_defines.svh -----
// Assertion macros for the backend pick block.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef WEIGHTED_ROUND_ROBIN_BACKEND_PICK_DEFINES_SVH
`define WEIGHTED_ROUND_ROBIN_BACKEND_PICK_DEFINES_SVH

// same-cycle implication
`define WRRBP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WRRBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/wrrbp_pkg.sv -----
// Shared types, codes and helpers for the backend pick block.
// No dependencies.
`default_nettype none

package wrrbp_pkg;

	localparam int IDX_W    = 4;
	localparam int TYPE_W   = 2;
	localparam int STATE_W  = 3;
	localparam int WEIGHT_W = 4;
	localparam int STAT_W   = 2;
	localparam int ACT_W    = 2;
	localparam int ROT_W    = 32;
	localparam int WEIGHT_ALL_ONES = (1 << WEIGHT_W) - 1;

	localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MODIFY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PICK_RO = 2'd2;
	localparam logic [ACT_W-1:0] ACT_PICK_RW = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NONE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;

	localparam logic [TYPE_W-1:0] TYPE_RW = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_RO = 2'd2;

	localparam logic [STATE_W-1:0] HEALTH_UNKNOWN = 3'd0;
	localparam logic [STATE_W-1:0] HEALTH_UP      = 3'd1;

	// stored slot contents; presence lives in flops outside the RAM
	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [STATE_W-1:0]  health;
		logic [TYPE_W-1:0]   kind;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_WRITE  = 8'b0000_0010,
		S_MODRD  = 8'b0000_0100,
		S_MODCHK = 8'b0000_1000,
		S_SCAN1  = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_SCAN2  = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} fsm_t;

	function automatic logic slot_usable(input entry_t e, input logic [TYPE_W-1:0] want);
		slot_usable = (e.kind == want) &&
			((e.health == HEALTH_UP) || (e.health == HEALTH_UNKNOWN));
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wrrbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wrrbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/wrrbp_mod.sv -----
// Bit-serial remainder unit: 32-bit dividend modulo a small divisor, one bit per cycle.
// Depends on wrrbp_pkg.
`default_nettype none

module wrrbp_mod #(
	parameter int DIV_W = 5
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire [wrrbp_pkg::ROT_W-1:0] dividend,
	input  wire [DIV_W-1:0]            divisor,
	output logic                       done,
	output logic [DIV_W-1:0]           rem
);
	import wrrbp_pkg::*;

	localparam int STEP_W = $clog2(ROT_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [ROT_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  rem_q;
	logic              done_q;

	logic [DIV_W:0]    trial;
	logic              fits;
	logic [DIV_W-1:0]  rem_d;

	assign trial = {rem_q, dvd_q[ROT_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign rem_d = fits ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ROT_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ROT_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/weighted_round_robin_backend_pick.sv -----
// Backend pick table: slot writes, compare-and-swap modifies, rotating and first-fit picks.
// Depends on wrrbp_pkg, wrrbp_ram, wrrbp_mod and weighted_round_robin_backend_pick_defines.svh.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser: action; s_tdata: index..old_state
//  m_      | out | m_tvalid/m_tready  | m_tdata: status, picked_index
//  cfg_    | in  | cfg_we             | cfg_wdata: prio_en
//
// One item at a time; a write runs S_WRITE, S_RESULT and a modify S_MODRD, S_MODCHK, S_RESULT before m_tvalid.
// Read-write pick: one table scan, one table read per cycle through the single RAM read port.
// Read-only pick: a weight/count scan, the bit-serial remainder unit, then a second scan
// to locate the position; with no eligible slot it ends after the first scan.
// Reset clears presence flops, the rotation counter and mode at once; no clearing pass.
// A finished result sits in the output register; the next item is taken while it waits.
`default_nettype none

module weighted_round_robin_backend_pick #(
	parameter int TABLE_ENTRIES = 16,
	parameter int WEIGHT_LIMIT  = 15
) (
	input  wire         clk,
	input  wire         arst_n,
	// slave side
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // entry_index[3:0], entry_type[5:4], entry_state[8:6],
	                               // entry_weight[12:9], check_old[13], old_state[16:14]
	input  wire  [1:0]  s_tuser,   // action[1:0]
	// master side
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // status[1:0], picked_index[5:2]
	// configuration
	input  wire         cfg_we,
	input  wire         cfg_wdata  // prio_en
);
	import wrrbp_pkg::*;

	`include "weighted_round_robin_backend_pick_defines.svh"

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int XW = AW + IDX_W + 1;
	localparam int WCAP_I = (WEIGHT_LIMIT > WEIGHT_ALL_ONES) ? WEIGHT_ALL_ONES : WEIGHT_LIMIT;
	localparam logic [WEIGHT_W-1:0] W_CAP = WEIGHT_W'(WCAP_I);

	// FSM and control
	fsm_t              state_q, state_d;
	logic              prio_q;
	logic [TABLE_ENTRIES-1:0] present_q;
	logic [ROT_W-1:0]  rot_q;
	logic [AW:0]       iss_q;      // next slot to read during a scan
	logic              vld_s1;     // RAM data for idx_s1 arrives this cycle
	logic [AW-1:0]     idx_s1;
	logic              any_q;
	logic              found_q;
	logic [CW-1:0]     nall_q;     // active slots of the requested type
	logic [CW-1:0]     ntop_q;     // of those, at the highest weight
	logic [CW-1:0]     seen_q;
	logic              m_tvalid_q;

	// captured item and working payload
	logic [ACT_W-1:0]    act_q;
	logic [IDX_W-1:0]    idx_q;
	logic [TYPE_W-1:0]   typ_q;
	logic [STATE_W-1:0]  st_q;
	logic [WEIGHT_W-1:0] wt_q;
	logic                chk_q;
	logic [STATE_W-1:0]  old_q;
	logic [WEIGHT_W-1:0] top_q;
	logic [AW-1:0]       pick_q;
	logic [CW-1:0]       num_q;
	logic [CW-1:0]       pos_q;
	logic [STAT_W-1:0]   res_st_q;
	logic [7:0]          m_tdata_q;

	// RAM ports
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	entry_t              ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;
	entry_t              rd_ent;

	// datapath terms
	logic                in_accept;
	logic                scanning, issue, scan_end;
	logic                in_range;
	logic [AW-1:0]       idx_addr;
	logic [WEIGHT_W-1:0] w_clamp;
	logic [TYPE_W-1:0]   want_type;
	logic                slot_on, slot_elig;
	logic [CW-1:0]       num_sel;
	logic                mod_ok;
	logic                ld_res;
	logic                mod_start, mod_done;
	logic [CW-1:0]       mod_rem;

	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;

	assign idx_addr = AW'(idx_q);
	assign in_range = XW'(idx_q) < XW'(TABLE_ENTRIES);
	assign w_clamp  = (wt_q > W_CAP) ? W_CAP : wt_q;

	assign scanning = (state_q == S_SCAN1) || (state_q == S_SCAN2);
	assign issue    = scanning && (iss_q < (AW+1)'(TABLE_ENTRIES));
	assign scan_end = scanning && (iss_q == (AW+1)'(TABLE_ENTRIES)) && !vld_s1;

	assign rd_ent    = entry_t'(ram_rdata);
	assign want_type = (act_q == ACT_PICK_RW) ? TYPE_RW : TYPE_RO;
	assign slot_on   = vld_s1 && present_q[idx_s1] && slot_usable(rd_ent, want_type);
	assign slot_elig = slot_on && (!prio_q || (rd_ent.weight == top_q));
	assign num_sel   = prio_q ? ntop_q : nall_q;

	// CAS: for a present, in-range slot, a same-state modify or an unchecked one always passes
	assign mod_ok = in_range && present_q[idx_addr] &&
		(!chk_q || (rd_ent.health == st_q) || (rd_ent.health == old_q));

	assign ld_res = (state_q == S_RESULT) && (!m_tvalid_q || m_tready);

	assign mod_start = (state_q == S_SCAN1) && scan_end && (act_q == ACT_PICK_RO) &&
		(num_sel != '0);

	// RAM control
	always_comb begin
		ram_re    = issue || (state_q == S_MODRD);
		ram_raddr = (state_q == S_MODRD) ? idx_addr : iss_q[AW-1:0];
		ram_waddr = idx_addr;
		ram_we    = ((state_q == S_WRITE) && in_range) || ((state_q == S_MODCHK) && mod_ok);
		ram_wdata.kind   = typ_q;
		ram_wdata.health = st_q;
		ram_wdata.weight = (state_q == S_WRITE) ? w_clamp : rd_ent.weight;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					case (s_tuser)
						ACT_WRITE:  state_d = S_WRITE;
						ACT_MODIFY: state_d = S_MODRD;
						default:    state_d = S_SCAN1;
					endcase
				end
			end
			S_WRITE:  state_d = S_RESULT;
			S_MODRD:  state_d = S_MODCHK;
			S_MODCHK: state_d = S_RESULT;
			S_SCAN1: begin
				if (scan_end) begin
					state_d = mod_start ? S_DIV : S_RESULT;
				end
			end
			S_DIV: begin
				if (mod_done) begin
					state_d = S_SCAN2;
				end
			end
			S_SCAN2: begin
				if (scan_end) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (ld_res) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			prio_q     <= 1'b0;
			present_q  <= '0;
			rot_q      <= '0;
			iss_q      <= '0;
			vld_s1     <= 1'b0;
			any_q      <= 1'b0;
			found_q    <= 1'b0;
			nall_q     <= '0;
			ntop_q     <= '0;
			seen_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				prio_q <= cfg_wdata;
			end
			if ((state_q == S_WRITE) && in_range) begin
				present_q[idx_addr] <= 1'b1;
			end

			vld_s1 <= issue;
			if (issue) begin
				iss_q <= iss_q + (AW+1)'(1);
			end

			if (in_accept) begin
				iss_q   <= '0;
				any_q   <= 1'b0;
				found_q <= 1'b0;
				nall_q  <= '0;
				ntop_q  <= '0;
			end

			// pass one: counts and first hit
			if ((state_q == S_SCAN1) && slot_on) begin
				any_q  <= 1'b1;
				nall_q <= nall_q + CW'(1);
				if (!any_q || (rd_ent.weight > top_q)) begin
					ntop_q <= CW'(1);
				end else if (rd_ent.weight == top_q) begin
					ntop_q <= ntop_q + CW'(1);
				end
				if (!found_q) begin
					found_q <= 1'b1;
				end
			end

			if ((state_q == S_DIV) && mod_done) begin
				iss_q   <= '0;
				seen_q  <= '0;
				found_q <= 1'b0;
			end

			// pass two: walk to the rotation position
			if ((state_q == S_SCAN2) && slot_elig && !found_q) begin
				seen_q <= seen_q + CW'(1);
				if (seen_q == pos_q) begin
					found_q <= 1'b1;
				end
			end
			if ((state_q == S_SCAN2) && scan_end) begin
				rot_q <= rot_q + ROT_W'(1);
			end

			if (ld_res) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[AW-1:0];
		if (in_accept) begin
			act_q  <= s_tuser;
			idx_q  <= s_tdata[3:0];
			typ_q  <= s_tdata[5:4];
			st_q   <= s_tdata[8:6];
			wt_q   <= s_tdata[12:9];
			chk_q  <= s_tdata[13];
			old_q  <= s_tdata[16:14];
			pick_q <= '0;
		end
		if ((state_q == S_SCAN1) && slot_on) begin
			if (!any_q || (rd_ent.weight > top_q)) begin
				top_q <= rd_ent.weight;
			end
			if (!found_q) begin
				pick_q <= idx_s1;
			end
		end
		if ((state_q == S_SCAN2) && slot_elig && !found_q && (seen_q == pos_q)) begin
			pick_q <= idx_s1;
		end
		if (mod_start) begin
			num_q <= num_sel;
		end
		if ((state_q == S_DIV) && mod_done) begin
			pos_q <= mod_rem;
		end

		case (state_q)
			S_WRITE:  res_st_q <= STAT_OK;
			S_MODCHK: res_st_q <= mod_ok ? STAT_OK : STAT_REJECT;
			S_SCAN1: begin
				if (scan_end) begin
					res_st_q <= (act_q == ACT_PICK_RW) ?
						(found_q ? STAT_OK : STAT_NONE) : STAT_NONE;
				end
			end
			S_SCAN2:  res_st_q <= STAT_OK;
			default:  res_st_q <= res_st_q;
		endcase

		if (ld_res) begin
			m_tdata_q <= {2'b00, IDX_W'(pick_q), res_st_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	wrrbp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wrrbp_mod #(
		.DIV_W (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (rot_q),
		.divisor  (num_sel),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// checks
	`WRRBP_ASSERT_NOW(a_no_overwrite, ld_res, !m_tvalid_q || m_tready,
		"result loaded over a pending item")
	`WRRBP_ASSERT_NOW(a_rem_in_range, mod_done, mod_rem < num_q,
		"rotation position beyond eligible count")
	`WRRBP_ASSERT_NEXT(a_rot_advance, (state_q == S_SCAN2) && scan_end,
		rot_q == $past(rot_q) + ROT_W'(1), "rotation counter did not advance")
	`WRRBP_ASSERT_NOW(a_pick_present,
		ld_res && (res_st_q == STAT_OK) && ((act_q == ACT_PICK_RO) || (act_q == ACT_PICK_RW)),
		present_q[pick_q], "picked slot is absent")
	`WRRBP_ASSERT_NOW(a_scan_found, (state_q == S_SCAN2) && scan_end, found_q,
		"second pass missed the rotation position")

endmodule

`default_nettype wire
